// ----- rtl/core/med_predictive_pixel_codec_assert.svh -----
// Assertion macros shared by the pixel codec RTL.
// Included by files that check their own pipeline behavior; no other dependencies.
`ifndef MED_PREDICTIVE_PIXEL_CODEC_ASSERT_SVH
`define MED_PREDICTIVE_PIXEL_CODEC_ASSERT_SVH

// same-cycle implication
`define MED_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MED_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/med_pkg.sv -----
// Package for the MED pixel codec: sizes, register indexes and stage structs.
// No dependencies; imported by the control, prediction and top-level modules.
`default_nettype none

package med_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int PIX_W  = 8;
   localparam int RES_W  = 9;
   localparam int SIZE_W = 11;
   localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   // wide enough to compare any register value against the maxima
   localparam int EXT_W  = 18;

   localparam int RESET_SIZE = 1024;
   localparam int PIX_MAX    = 255;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_DECODE_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd2;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   // request held in the lookup stage while the line store read completes
   typedef struct packed {
      logic [PIX_W-1:0]        pixel;
      logic signed [RES_W-1:0] residual;
      logic [COL_W-1:0]        col;
      logic                    first;
      logic                    top_row;
      logic                    left_col;
      logic                    last;
   } stage_type;

   typedef struct packed {
      logic             en;
      logic [COL_W-1:0] addr;
   } ram_rd_type;

   typedef struct packed {
      logic             en;
      logic [COL_W-1:0] addr;
      logic [PIX_W-1:0] data;
   } ram_wr_type;

endpackage

`default_nettype wire

// ----- rtl/core/med_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Self-contained; the read data holds when no read is issued.
`default_nettype none

module med_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/med_ctrl.sv -----
// Control for the MED pixel codec: configuration registers, raster counters,
// line store read issue and the lookup stage register. Uses med_pkg.
`default_nettype none

module med_ctrl (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [med_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [med_pkg::SIZE_W-1:0]      csr_wdata,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [med_pkg::PIX_W-1:0]       req_pixel,
   input  wire logic signed [med_pkg::RES_W-1:0] req_residual,
   input  wire logic                            advance,
   output logic                                 decode_mode,
   output logic                                 stage_valid,
   output med_pkg::stage_type                   stage,
   output med_pkg::ram_rd_type                  ram_rd
);
   import med_pkg::*;

   logic              decode_mode_ff;
   logic [SIZE_W-1:0] width_ff;
   logic [SIZE_W-1:0] height_ff;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              stage_valid_ff, stage_valid_in;
   stage_type         stage_ff, stage_in;

   logic [COL_W:0]    eff_w;
   logic [ROW_W:0]    eff_h;
   logic              wrap;
   logic [COL_W-1:0]  col;
   logic [ROW_W-1:0]  row;
   logic [COL_W:0]    col_next;
   logic [ROW_W:0]    row_next;
   logic              accept;

   // clamp frame size to 1..max
   always_comb begin
      if (EXT_W'(width_ff) > EXT_W'(MAX_WIDTH)) begin
         eff_w = (COL_W + 1)'(MAX_WIDTH);
      end else if (width_ff == '0) begin
         eff_w = (COL_W + 1)'(1);
      end else begin
         eff_w = (COL_W + 1)'(width_ff);
      end
      if (EXT_W'(height_ff) > EXT_W'(MAX_HEIGHT)) begin
         eff_h = (ROW_W + 1)'(MAX_HEIGHT);
      end else if (height_ff == '0) begin
         eff_h = (ROW_W + 1)'(1);
      end else begin
         eff_h = (ROW_W + 1)'(height_ff);
      end
   end

   assign req_tready = !stage_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      // restart the frame when the size shrank below the counters
      wrap     = ({1'b0, col_ff} >= eff_w) || ({1'b0, row_ff} >= eff_h);
      col      = wrap ? '0 : col_ff;
      row      = wrap ? '0 : row_ff;
      col_next = {1'b0, col} + (COL_W + 1)'(1);
      row_next = {1'b0, row} + (ROW_W + 1)'(1);

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_next >= eff_w) begin
            col_in = '0;
            row_in = (row_next >= eff_h) ? '0 : row_next[ROW_W-1:0];
         end else begin
            col_in = col_next[COL_W-1:0];
            row_in = row;
         end
      end

      stage_in.pixel    = req_pixel;
      stage_in.residual = req_residual;
      stage_in.col      = col;
      stage_in.first    = (col == '0) && (row == '0);
      stage_in.top_row  = (row == '0);
      stage_in.left_col = (col == '0);
      stage_in.last     = ({1'b0, col} == eff_w - (COL_W + 1)'(1)) &&
                          ({1'b0, row} == eff_h - (ROW_W + 1)'(1));

      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decode_mode_ff <= 1'b0;
         width_ff       <= SIZE_W'(RESET_SIZE);
         height_ff      <= SIZE_W'(RESET_SIZE);
         col_ff         <= '0;
         row_ff         <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_DECODE_MODE:  decode_mode_ff <= csr_wdata[0];
               CSR_FRAME_WIDTH:  width_ff       <= csr_wdata;
               CSR_FRAME_HEIGHT: height_ff      <= csr_wdata;
               default: ;
            endcase
         end
         col_ff         <= col_in;
         row_ff         <= row_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

   assign decode_mode = decode_mode_ff;
   assign stage_valid = stage_valid_ff;
   assign stage       = stage_ff;
   assign ram_rd.en   = accept;
   assign ram_rd.addr = col;

endmodule

`default_nettype wire

// ----- rtl/core/med_pred.sv -----
// Prediction datapath for the MED pixel codec: neighbor registers, forwarding
// around the line store, residual/pixel math and the response register. Uses med_pkg.
`default_nettype none

module med_pred (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              decode_mode,
   input  wire logic                              stage_valid,
   input  wire med_pkg::stage_type                stage,
   input  wire med_pkg::ram_rd_type               ram_rd,
   input  wire logic [med_pkg::PIX_W-1:0]         ram_rdata,
   output logic                                   advance,
   output med_pkg::ram_wr_type                    ram_wr,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic signed [med_pkg::RES_W-1:0]       rsp_residual,
   output logic [med_pkg::PIX_W-1:0]              rsp_pixel,
   output logic                                   rsp_last
);
   import med_pkg::*;

   logic [PIX_W-1:0]        left_ff, upper_left_ff;
   logic                    fwd_ff;
   logic [PIX_W-1:0]        fwd_pix_ff;
   logic                    rsp_valid_ff;
   logic signed [RES_W-1:0] rsp_residual_ff;
   logic [PIX_W-1:0]        rsp_pixel_ff;
   logic                    rsp_last_ff;

   logic [PIX_W-1:0]        upper, mx, mn, pred;
   logic [PIX_W+1:0]        grad;
   logic signed [RES_W-1:0] res_sat, res_enc, res;
   logic signed [RES_W+1:0] val;
   logic [PIX_W-1:0]        pix;

   assign advance = stage_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      upper = fwd_ff ? fwd_pix_ff : ram_rdata;
      mx    = (left_ff > upper) ? left_ff : upper;
      mn    = (left_ff > upper) ? upper : left_ff;
      grad  = {2'b00, left_ff} + {2'b00, upper} - {2'b00, upper_left_ff};

      if (stage.first) begin
         pred = '0;
      end else if (stage.top_row) begin
         pred = left_ff;
      end else if (stage.left_col) begin
         pred = upper;
      end else if (upper_left_ff >= mx) begin
         pred = mn;
      end else if (upper_left_ff <= mn) begin
         pred = mx;
      end else begin
         pred = grad[PIX_W-1:0];
      end

      // the only code outside +/-255 is the most negative one
      res_sat = (stage.residual == {1'b1, {(RES_W - 1){1'b0}}}) ?
                {1'b1, {(RES_W - 2){1'b0}}, 1'b1} : stage.residual;

      if (stage.first) begin
         val = (RES_W + 2)'(res_sat);
      end else begin
         val = $signed({3'b000, pred}) - (RES_W + 2)'(res_sat);
      end

      res_enc = stage.first ? $signed({1'b0, stage.pixel}) :
                $signed({1'b0, pred}) - $signed({1'b0, stage.pixel});

      if (decode_mode) begin
         res = res_sat;
         if (val < 0) begin
            pix = '0;
         end else if (val > (RES_W + 2)'(PIX_MAX)) begin
            pix = PIX_W'(PIX_MAX);
         end else begin
            pix = val[PIX_W-1:0];
         end
      end else begin
         res = res_enc;
         pix = stage.pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff       <= '0;
         upper_left_ff <= '0;
         fwd_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (advance) begin
            left_ff       <= pix;
            upper_left_ff <= upper;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff  <= 1'b0;
         end
         // a read that lands on the entry written this cycle returns stale data
         if (ram_rd.en) begin
            fwd_ff <= advance && (ram_rd.addr == stage.col);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ram_rd.en) begin
         fwd_pix_ff <= pix;
      end
      if (advance) begin
         rsp_residual_ff <= res;
         rsp_pixel_ff    <= pix;
         rsp_last_ff     <= stage.last;
      end
   end

   assign ram_wr.en     = advance;
   assign ram_wr.addr   = stage.col;
   assign ram_wr.data   = pix;
   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_residual  = rsp_residual_ff;
   assign rsp_pixel     = rsp_pixel_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

`default_nettype wire

// ----- rtl/core/med_predictive_pixel_codec.sv -----
// MED predictive pixel codec. Takes one 8-bit pixel (encode) or 9-bit residual
// (decode) per request in raster order and returns one response per request:
// the residual, the pixel and a frame-end flag on tlast. A request is accepted
// every cycle when the response side keeps up; an accepted request waits in
// the lookup stage register while the line store read completes, then the
// prediction fills the response register. The previous row sits in a single
// synchronous RAM read at acceptance and written back when the request leaves
// the lookup stage; one-pixel-wide frames are served by forwarding.
// Configuration writes go straight to the registers and belong only in idle
// periods. Depends on med_pkg, med_ram, med_ctrl and med_pred.
`default_nettype none

module med_predictive_pixel_codec (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [med_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [med_pkg::SIZE_W-1:0]        csr_wdata,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [7:0] pixel_in, [16:8] residual_in, [23:17] zero
   input  wire logic [med_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [8:0] residual_out, [16:9] pixel_out, [23:17] zero
   output logic [med_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic                                   rsp_tlast
);
   import med_pkg::*;
   `include "med_predictive_pixel_codec_assert.svh"

   logic                    decode_mode;
   logic                    stage_valid;
   logic                    advance;
   stage_type               stage;
   ram_rd_type              ram_rd;
   ram_wr_type              ram_wr;
   logic [PIX_W-1:0]        ram_rdata;
   logic signed [RES_W-1:0] rsp_residual;
   logic [PIX_W-1:0]        rsp_pixel;

   med_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_pixel    (req_tdata[PIX_W-1:0]),
      .req_residual (req_tdata[PIX_W+RES_W-1:PIX_W]),
      .advance      (advance),
      .decode_mode  (decode_mode),
      .stage_valid  (stage_valid),
      .stage        (stage),
      .ram_rd       (ram_rd)
   );

   med_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (ram_rd.en),
      .rd_addr (ram_rd.addr),
      .rd_data (ram_rdata)
   );

   med_pred u_pred (
      .clock        (clock),
      .reset        (reset),
      .decode_mode  (decode_mode),
      .stage_valid  (stage_valid),
      .stage        (stage),
      .ram_rd       (ram_rd),
      .ram_rdata    (ram_rdata),
      .advance      (advance),
      .ram_wr       (ram_wr),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_residual (rsp_residual),
      .rsp_pixel    (rsp_pixel),
      .rsp_last     (rsp_tlast)
   );

   assign rsp_tdata = {{(RSP_DATA_W - RES_W - PIX_W){1'b0}}, rsp_pixel, rsp_residual};

   `MED_ASSERT_IMPL(a_stall_blocks_request, clock, reset, stage_valid && !advance,
      !req_tready, "request accepted while lookup stage is stalled")
   `MED_ASSERT_NEXT(a_request_loads_stage, clock, reset, req_tvalid && req_tready,
      stage_valid, "accepted request missing from lookup stage")
   `MED_ASSERT_NEXT(a_advance_fills_response, clock, reset, advance,
      rsp_tvalid, "advanced request did not reach the response register")
   `MED_ASSERT_IMPL(a_write_from_stage, clock, reset, ram_wr.en,
      stage_valid && (rsp_tready || !rsp_tvalid), "line store written without a request")

endmodule

`default_nettype wire

// ----- sim/med_predictive_pixel_codec_tb.sv -----
// Self-checking testbench for med_predictive_pixel_codec: encode and decode over many frame sizes.
// It predicts every response with a scoreboard class and drives the block with idling on both sides.
// Needs med_pkg and the codec RTL only.
module med_predictive_pixel_codec_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import med_pkg::*;

   localparam int CLK_PERIOD   = 8;
   localparam int RANDOM_ITEMS = 300;
   localparam int WIDE_ITEMS   = MAX_WIDTH + 48;
   localparam int SETTLE       = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam bit MODE_ENCODE = 1'b0;
   localparam bit MODE_DECODE = 1'b1;

   typedef struct packed {
      logic signed [RES_W-1:0] residual;
      logic [PIX_W-1:0]        pixel;
      logic                    frame_end;
   } codec_result_type;

   class codec_scoreboard;
      bit                decode_on;
      logic [SIZE_W-1:0] width_reg;
      logic [SIZE_W-1:0] height_reg;
      logic [PIX_W-1:0]  line_buf [MAX_WIDTH];
      logic [PIX_W-1:0]  left_pix;
      logic [PIX_W-1:0]  upleft_pix;
      int unsigned       col_cnt;
      int unsigned       row_cnt;
      codec_result_type  results_due [$];
      int unsigned       errors;
      int unsigned       responses_seen;

      function new();
         decode_on  = MODE_ENCODE;
         width_reg  = SIZE_W'(RESET_SIZE);
         height_reg = SIZE_W'(RESET_SIZE);
         foreach (line_buf[i]) line_buf[i] = '0;
         left_pix   = '0;
         upleft_pix = '0;
         col_cnt    = 0;
         row_cnt    = 0;
      endfunction

      // zero acts as one, anything above the maximum as the maximum
      static function int unsigned clip_size(logic [SIZE_W-1:0] v, int unsigned mx);
         if (v == 0) return 1;
         if (v > mx) return mx;
         return v;
      endfunction

      function int unsigned eff_width();
         return clip_size(width_reg, MAX_WIDTH);
      endfunction

      function int unsigned eff_height();
         return clip_size(height_reg, MAX_HEIGHT);
      endfunction

      function bit at_frame_start();
         return (col_cnt == 0 && row_cnt == 0) || col_cnt >= eff_width() ||
                row_cnt >= eff_height();
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
         case (idx)
            CSR_DECODE_MODE:  decode_on  = val[0];
            CSR_FRAME_WIDTH:  width_reg  = val;
            CSR_FRAME_HEIGHT: height_reg = val;
            default: ;
         endcase
      endfunction

      static function int clip_pixel(int v);
         return v < 0 ? 0 : (v > PIX_MAX ? PIX_MAX : v);
      endfunction

      // median edge detector over left, upper and upper-left neighbors
      static function int med_of(int a, int b, int c);
         int hi;
         int lo;
         hi = a > b ? a : b;
         lo = a > b ? b : a;
         if (c >= hi) return lo;
         if (c <= lo) return hi;
         return a + b - c;
      endfunction

      function void note_request(logic [PIX_W-1:0] pix_in, logic [RES_W-1:0] res_in);
         int unsigned      w;
         int unsigned      h;
         int               upper;
         int               pred;
         int               pix;
         int               res;
         bit               first;
         codec_result_type want;
         w = eff_width();
         h = eff_height();
         if (col_cnt >= w || row_cnt >= h) begin
            col_cnt = 0;
            row_cnt = 0;
         end
         upper = line_buf[col_cnt];
         first = (col_cnt == 0 && row_cnt == 0);
         if (first) pred = 0;
         else if (row_cnt == 0) pred = left_pix;
         else if (col_cnt == 0) pred = upper;
         else pred = med_of(left_pix, upper, upleft_pix);
         if (decode_on == MODE_DECODE) begin
            res = $signed(res_in);
            if (res < -PIX_MAX) res = -PIX_MAX;
            pix = first ? clip_pixel(res) : clip_pixel(pred - res);
         end else begin
            pix = pix_in;
            res = first ? pix : pred - pix;
         end
         want.residual  = res[RES_W-1:0];
         want.pixel     = pix[PIX_W-1:0];
         want.frame_end = (col_cnt == w - 1 && row_cnt == h - 1);
         results_due.push_back(want);
         upleft_pix        = upper[PIX_W-1:0];
         line_buf[col_cnt] = pix[PIX_W-1:0];
         left_pix          = pix[PIX_W-1:0];
         col_cnt++;
         if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= h) row_cnt = 0;
         end
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] data, logic last);
         codec_result_type got;
         codec_result_type want;
         got.residual  = data[RES_W-1:0];
         got.pixel     = data[RES_W +: PIX_W];
         got.frame_end = last;
         responses_seen++;
         if (results_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected response: residual %0d pixel %0d last %0b",
                     $time, got.residual, got.pixel, got.frame_end);
            return;
         end
         want = results_due.pop_front();
         if (got.residual !== want.residual || got.pixel !== want.pixel ||
             got.frame_end !== want.frame_end) begin
            errors++;
            $display("%0t: response %0d mismatch: expected residual %0d pixel %0d last %0b,",
                     $time, responses_seen, want.residual, want.pixel, want.frame_end,
                     " got residual %0d pixel %0d last %0b",
                     got.residual, got.pixel, got.frame_end);
         end
      endfunction

      function int unsigned pending();
         return results_due.size();
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [SIZE_W-1:0]     csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   codec_scoreboard sb;
   int unsigned     tx_idle_pct = 0;
   int unsigned     rx_stall_pct = 0;
   int unsigned     requests_sent = 0;
   int unsigned     settings_applied = 0;
   logic [PIX_W-1:0] prev_pixel = '0;

   logic [PIX_W-1:0] edge_pixels [12] = '{
      8'd255, 8'd0, 8'd255, 8'd0,
      8'd0, 8'd255, 8'd0, 8'd255,
      8'd128, 8'd128, 8'd255, 8'd0
   };
   logic [RES_W-1:0] edge_residuals [6] = '{
      RES_W'(-256), RES_W'(-255), RES_W'(255), RES_W'(0), RES_W'(100), RES_W'(-100)
   };

   med_predictive_pixel_codec u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      // [7:0] pixel_in, [16:8] residual_in, [23:17] zero
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      // [8:0] residual_out, [16:9] pixel_out, [23:17] zero
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tlast);
      rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
   end

   task automatic send_request(input logic [PIX_W-1:0] pix, input logic [RES_W-1:0] res);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({res, pix});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(pix, res);
      requests_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   task automatic apply_setting(input bit mode, input logic [SIZE_W-1:0] width,
                                input logic [SIZE_W-1:0] height);
      logic [SIZE_W-1:0] mode_word;
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      // hold the width mid-frame unless it shrinks: the line store must be written first
      if (!sb.at_frame_start() &&
          codec_scoreboard::clip_size(width, MAX_WIDTH) > sb.eff_width())
         width = sb.width_reg;
      mode_word    = SIZE_W'($urandom);
      mode_word[0] = mode;
      csr_write(CSR_UNUSED, SIZE_W'($urandom));
      csr_write(CSR_DECODE_MODE, mode_word);
      csr_write(CSR_FRAME_WIDTH, width);
      csr_write(CSR_FRAME_HEIGHT, height);
      csr_we <= 1'b0;
      settings_applied++;
   endtask

   // mostly smooth images and small residuals, with full-range noise mixed in
   task automatic run_random_phase(input int unsigned n, input bit with_pause);
      logic [PIX_W-1:0] pix;
      logic [RES_W-1:0] res;
      int unsigned      roll;
      for (int unsigned i = 0; i < n; i++) begin
         if (with_pause && i == n / 2) wait_drained();
         pix  = PIX_W'($urandom);
         res  = RES_W'($urandom);
         roll = $urandom_range(99);
         if (roll < 70) begin
            pix = prev_pixel + PIX_W'($urandom_range(8)) - PIX_W'(4);
            res = RES_W'(int'($urandom_range(16)) - 8);
         end else if (roll < 73) begin
            res = RES_W'(-256);
         end
         prev_pixel = pix;
         send_request(pix, res);
      end
   endtask

   function automatic logic [SIZE_W-1:0] pick_size(input int unsigned usual_max);
      int unsigned roll;
      roll = $urandom_range(19);
      if (roll == 0) return '0;
      if (roll == 1) return SIZE_W'($urandom_range(MAX_WIDTH + 1, 2 ** SIZE_W - 1));
      if (roll == 2) return SIZE_W'(1);
      return SIZE_W'($urandom_range(1, usual_max));
   endfunction

   initial begin
      int unsigned random_start;
      int unsigned phase_no;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      apply_setting(MODE_ENCODE, 4, 3);
      foreach (edge_pixels[i]) send_request(edge_pixels[i], RES_W'($urandom));
      apply_setting(MODE_DECODE, 3, 2);
      foreach (edge_residuals[i]) send_request(PIX_W'($urandom), edge_residuals[i]);
      apply_setting(MODE_DECODE, 0, 0);
      send_request(PIX_W'($urandom), RES_W'(-10));
      send_request(PIX_W'($urandom), RES_W'(255));

      // widest row, then into the second row so line store entries from the full-width row are read back
      apply_setting(MODE_ENCODE, 2047, 2);
      run_random_phase(WIDE_ITEMS, 1'b0);

      random_start = requests_sent;
      phase_no     = 0;
      while (requests_sent - random_start < RANDOM_ITEMS) begin
         phase_no++;
         case (phase_no % 4)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 53; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 53; end
            default: begin tx_idle_pct = 22; rx_stall_pct = 22; end
         endcase
         apply_setting($urandom_range(1), pick_size(16), pick_size(8));
         run_random_phase($urandom_range(20, 120), phase_no % 5 == 2);
      end

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      $display("summary: %0d requests, %0d responses checked, %0d register settings",
               requests_sent, sb.responses_seen, settings_applied);
      $display("summary: encode and decode, sizes 0 to 2047, a 1024-wide row read back");
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // hard stop far beyond the slowest legal run
   initial begin
      #4_000_000;
      $display("tb: failure");
      $finish;
   end
endmodule
